>>> hdl/mtbs_pkg.sv
// Package for the min-time barrier scheduler: field widths, op/cause/CSR codes,
// the table entry layout, the FSM state type and the time compare helper.
// No dependencies.
package mtbs_pkg;

   // Default client table depth
   localparam int CLIENTS_DEFAULT = 32;

   // Field widths
   localparam int ID_W   = 16;
   localparam int SEC_W  = 31;
   localparam int NSEC_W = 30;
   localparam int CNT_W  = 6;
   localparam int OP_W   = 2;
   localparam int CAUSE_W = 2;

   // Stream payload widths (rounded up to whole bytes)
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 64;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CLIENTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTOSTART   = 1'd1;

   // Request kinds (code 3 is ignored)
   localparam logic [OP_W-1:0] OP_NOTIFY = 2'd0;
   localparam logic [OP_W-1:0] OP_START  = 2'd1;
   localparam logic [OP_W-1:0] OP_PAUSE  = 2'd2;

   // Result causes
   localparam logic [CAUSE_W-1:0] CAUSE_ECHO    = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_ADVANCE = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_ZERO    = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_DROPPED = 2'd3;

   localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

   // One client table entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SEC_W-1:0]  sec;
      logic [NSEC_W-1:0] nsec;
   } entry_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SEARCH    = 7'b0000010,
      ST_APPLY     = 7'b0000100,
      ST_MIN       = 7'b0001000,
      ST_CMP       = 7'b0010000,
      ST_EMIT_PEND = 7'b0100000,
      ST_EMIT_UPD  = 7'b1000000
   } state_type;

   // a < b, seconds first, then raw nanoseconds
   function automatic logic time_less(
      input logic [SEC_W-1:0]  a_sec,
      input logic [NSEC_W-1:0] a_nsec,
      input logic [SEC_W-1:0]  b_sec,
      input logic [NSEC_W-1:0] b_nsec
   );
      time_less = (a_sec < b_sec) || ((a_sec == b_sec) && (a_nsec < b_nsec));
   endfunction

endpackage

>>> hdl/min_time_barrier_scheduler_unit.sv
// Min-time barrier scheduler top level: client table in a synchronous memory,
// sequenced id search and minimum scan, output register.
// Depends on mtbs_pkg.
//
// Usage:
//  req_* carries one beat per command: notify (client id and time limit),
//  start, or toggle pause; the kind rides in req_tuser. rsp_* returns 0 to 2
//  beats per command (time, cause in rsp_tuser, rsp_tlast on the final beat).
//  csr_* writes min_clients and autostart; write only while the block is idle.
//  Timing: commands are taken one at a time. A notify runs the accept, the id
//  search over the filled entries (one memory read per cycle, stops at a hit),
//  the table write, then the minimum scan and the compare when the time update
//  runs, then its result beats one after another, each held while rsp_tready
//  is low. Start and unpause run the minimum scan and the compare (an empty
//  table skips both), then the beat.
//  Reset: table empty (fill count cleared), time zero, not running, not
//  paused, control registers cleared. No clearing pass is needed.
//  Stall: a result beat waits in the output register while rsp_tready is low;
//  the sequencer holds at its emit state until the register frees.
module min_time_barrier_scheduler_unit #(
   parameter int CLIENTS = mtbs_pkg::CLIENTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: client_id[15:0], limit_sec[46:16], limit_nanosec[76:47], zero pad
   input  logic [mtbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: op[1:0]
   input  logic [mtbs_pkg::OP_W-1:0]         req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: time_sec[30:0], time_nanosec[60:31], zero pad
   output logic [mtbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: cause[1:0]
   output logic [mtbs_pkg::CAUSE_W-1:0]      rsp_tuser,
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_we,
   input  logic [mtbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mtbs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int FILL_W = $clog2(CLIENTS + 1);
   localparam int SEC_W  = mtbs_pkg::SEC_W;
   localparam int NSEC_W = mtbs_pkg::NSEC_W;
   localparam int ID_W   = mtbs_pkg::ID_W;
   localparam int CNT_W  = mtbs_pkg::CNT_W;

   // ---------------- control registers
   mtbs_pkg::state_type       state_ff, state_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      running_ff, running_in;
   logic                      paused_ff, paused_in;
   logic [CNT_W-1:0]          min_clients_ff, min_clients_in;
   logic                      autostart_ff, autostart_in;
   logic                      issue_ff, issue_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      rd_last_ff, rd_last_in;
   logic                      pend_ff, pend_in;
   logic                      upd_emit_ff, upd_emit_in;
   logic                      first_ff, first_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // ---------------- payload registers
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   mtbs_pkg::entry_type       cmd_ff, cmd_in;
   logic [SEC_W-1:0]          now_sec_ff, now_sec_in;
   logic [NSEC_W-1:0]         now_nsec_ff, now_nsec_in;
   logic [SEC_W-1:0]          min_sec_ff, min_sec_in;
   logic [NSEC_W-1:0]         min_nsec_ff, min_nsec_in;
   logic [SEC_W-1:0]          pend_sec_ff, pend_sec_in;
   logic [NSEC_W-1:0]         pend_nsec_ff, pend_nsec_in;
   logic [mtbs_pkg::CAUSE_W-1:0] pend_cause_ff, pend_cause_in;
   logic [mtbs_pkg::CAUSE_W-1:0] upd_cause_ff, upd_cause_in;
   logic [SEC_W-1:0]          out_sec_ff, out_sec_in;
   logic [NSEC_W-1:0]         out_nsec_ff, out_nsec_in;
   logic [mtbs_pkg::CAUSE_W-1:0] out_cause_ff, out_cause_in;
   logic                      out_last_ff, out_last_in;

   // ---------------- client table memory
   mtbs_pkg::entry_type       table_mem [CLIENTS];
   mtbs_pkg::entry_type       rd_data_ff;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;

   // ---------------- helpers
   logic                      req_fire;
   logic                      out_free;
   logic                      out_load;
   logic [IDX_W-1:0]          last_idx;
   logic                      id_match;
   logic                      rd_less;
   logic                      now_less;
   logic                      has_room;
   logic [CNT_W-1:0]          count_bump;
   logic                      allow_upd;

   assign req_tready = (state_ff == mtbs_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = IDX_W'(fill_ff - FILL_W'(1));
   assign id_match   = (rd_data_ff.id == cmd_ff.id);
   assign rd_less    = mtbs_pkg::time_less(rd_data_ff.sec, rd_data_ff.nsec,
                                           min_sec_ff, min_nsec_ff);
   assign now_less   = mtbs_pkg::time_less(now_sec_ff, now_nsec_ff,
                                           min_sec_ff, min_nsec_ff);
   assign has_room   = (fill_ff < FILL_W'(CLIENTS));
   assign count_bump = (count_ff == mtbs_pkg::CNT_MAX) ? count_ff : count_ff + CNT_W'(1);

   // write port: known client gets its limit replaced, else next free slot
   assign mem_we    = (state_ff == mtbs_pkg::ST_APPLY) && (hit_ff || has_room);
   assign mem_waddr = hit_ff ? hit_idx_ff : fill_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= cmd_ff;
      end
      rd_data_ff <= table_mem[idx_ff];
   end

   // ---------------- sequencer
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      count_in       = count_ff;
      running_in     = running_ff;
      paused_in      = paused_ff;
      min_clients_in = min_clients_ff;
      autostart_in   = autostart_ff;
      issue_in       = 1'b0;
      rd_valid_in    = 1'b0;
      rd_last_in     = rd_last_ff;
      pend_in        = pend_ff;
      upd_emit_in    = upd_emit_ff;
      first_in       = first_ff;
      hit_in         = hit_ff;
      idx_in         = idx_ff;
      hit_idx_in     = hit_idx_ff;
      cmd_in         = cmd_ff;
      now_sec_in     = now_sec_ff;
      now_nsec_in    = now_nsec_ff;
      min_sec_in     = min_sec_ff;
      min_nsec_in    = min_nsec_ff;
      pend_sec_in    = pend_sec_ff;
      pend_nsec_in   = pend_nsec_ff;
      pend_cause_in  = pend_cause_ff;
      upd_cause_in   = upd_cause_ff;
      out_sec_in     = out_sec_ff;
      out_nsec_in    = out_nsec_ff;
      out_cause_in   = out_cause_ff;
      out_last_in    = out_last_ff;
      out_load       = 1'b0;
      allow_upd      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            mtbs_pkg::CSR_MIN_CLIENTS: min_clients_in = csr_wdata;
            mtbs_pkg::CSR_AUTOSTART:   autostart_in   = csr_wdata[0];
            default: ;
         endcase
      end

      // table read issue, shared by search and min scan
      if ((state_ff == mtbs_pkg::ST_SEARCH || state_ff == mtbs_pkg::ST_MIN) && issue_ff) begin
         rd_valid_in = 1'b1;
         rd_last_in  = (idx_ff == last_idx);
         if (idx_ff == last_idx) begin
            issue_in = 1'b0;
         end else begin
            issue_in = 1'b1;
            idx_in   = idx_ff + IDX_W'(1);
         end
      end

      case (state_ff)
         mtbs_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in.id   = req_tdata[15:0];
               cmd_in.sec  = req_tdata[46:16];
               cmd_in.nsec = req_tdata[76:47];
               pend_in     = 1'b0;
               upd_emit_in = 1'b0;
               hit_in      = 1'b0;
               idx_in      = '0;
               first_in    = 1'b1;
               case (req_tuser)
                  mtbs_pkg::OP_NOTIFY: begin
                     if (fill_ff == '0) begin
                        state_in = mtbs_pkg::ST_APPLY;
                     end else begin
                        state_in = mtbs_pkg::ST_SEARCH;
                        issue_in = 1'b1;
                     end
                  end
                  mtbs_pkg::OP_START: begin
                     running_in = 1'b1;
                     allow_upd  = 1'b1;
                  end
                  mtbs_pkg::OP_PAUSE: begin
                     paused_in = !paused_ff;
                     allow_upd = paused_ff;
                  end
                  default: ;
               endcase
               // time update on an empty table resets to zero
               if (allow_upd) begin
                  if (fill_ff == '0) begin
                     now_sec_in   = '0;
                     now_nsec_in  = '0;
                     upd_emit_in  = 1'b1;
                     upd_cause_in = mtbs_pkg::CAUSE_ZERO;
                     state_in     = mtbs_pkg::ST_EMIT_UPD;
                  end else begin
                     state_in = mtbs_pkg::ST_MIN;
                     issue_in = 1'b1;
                  end
               end
            end
         end

         // look up the client id, one entry per cycle
         mtbs_pkg::ST_SEARCH: begin
            if (rd_valid_ff && id_match) begin
               hit_in      = 1'b1;
               // the address stops advancing once the last entry is issued
               hit_idx_in  = rd_last_ff ? idx_ff : idx_ff - IDX_W'(1);
               issue_in    = 1'b0;
               rd_valid_in = 1'b0;
               idx_in      = idx_ff;
               state_in    = mtbs_pkg::ST_APPLY;
            end else if (rd_valid_ff && rd_last_ff) begin
               state_in = mtbs_pkg::ST_APPLY;
            end
         end

         // table write, registration and update gating
         mtbs_pkg::ST_APPLY: begin
            if (!hit_ff) begin
               pend_in      = 1'b1;
               pend_sec_in  = now_sec_ff;
               pend_nsec_in = now_nsec_ff;
               if (has_room) begin
                  pend_cause_in = mtbs_pkg::CAUSE_ECHO;
                  fill_in       = fill_ff + FILL_W'(1);
                  count_in      = count_bump;
               end else begin
                  pend_cause_in = mtbs_pkg::CAUSE_DROPPED;
               end
            end
            if (!paused_ff && running_ff) begin
               allow_upd = 1'b1;
            end else if (!paused_ff && autostart_ff && (count_in >= min_clients_ff)) begin
               running_in = 1'b1;
               allow_upd  = 1'b1;
            end
            idx_in   = '0;
            first_in = 1'b1;
            if (allow_upd) begin
               state_in = mtbs_pkg::ST_MIN;
               issue_in = 1'b1;
            end else if (pend_in) begin
               state_in = mtbs_pkg::ST_EMIT_PEND;
            end else begin
               state_in = mtbs_pkg::ST_IDLE;
            end
         end

         // minimum over the filled entries
         mtbs_pkg::ST_MIN: begin
            if (rd_valid_ff) begin
               first_in = 1'b0;
               if (first_ff || rd_less) begin
                  min_sec_in  = rd_data_ff.sec;
                  min_nsec_in = rd_data_ff.nsec;
               end
               if (rd_last_ff) begin
                  state_in = mtbs_pkg::ST_CMP;
               end
            end
         end

         // advance time if behind the minimum
         mtbs_pkg::ST_CMP: begin
            upd_emit_in = now_less;
            if (now_less) begin
               now_sec_in   = min_sec_ff;
               now_nsec_in  = min_nsec_ff;
               upd_cause_in = mtbs_pkg::CAUSE_ADVANCE;
            end
            if (pend_ff) begin
               state_in = mtbs_pkg::ST_EMIT_PEND;
            end else if (now_less) begin
               state_in = mtbs_pkg::ST_EMIT_UPD;
            end else begin
               state_in = mtbs_pkg::ST_IDLE;
            end
         end

         // echo or dropped beat
         mtbs_pkg::ST_EMIT_PEND: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_sec_in   = pend_sec_ff;
               out_nsec_in  = pend_nsec_ff;
               out_cause_in = pend_cause_ff;
               out_last_in  = !upd_emit_ff;
               pend_in      = 1'b0;
               state_in     = upd_emit_ff ? mtbs_pkg::ST_EMIT_UPD : mtbs_pkg::ST_IDLE;
            end
         end

         // time update beat
         mtbs_pkg::ST_EMIT_UPD: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_sec_in   = now_sec_ff;
               out_nsec_in  = now_nsec_ff;
               out_cause_in = upd_cause_ff;
               out_last_in  = 1'b1;
               upd_emit_in  = 1'b0;
               state_in     = mtbs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mtbs_pkg::ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mtbs_pkg::ST_IDLE;
         fill_ff        <= '0;
         count_ff       <= '0;
         running_ff     <= 1'b0;
         paused_ff      <= 1'b0;
         min_clients_ff <= '0;
         autostart_ff   <= 1'b0;
         issue_ff       <= 1'b0;
         rd_valid_ff    <= 1'b0;
         rd_last_ff     <= 1'b0;
         pend_ff        <= 1'b0;
         upd_emit_ff    <= 1'b0;
         first_ff       <= 1'b0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         now_sec_ff     <= '0;
         now_nsec_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         count_ff       <= count_in;
         running_ff     <= running_in;
         paused_ff      <= paused_in;
         min_clients_ff <= min_clients_in;
         autostart_ff   <= autostart_in;
         issue_ff       <= issue_in;
         rd_valid_ff    <= rd_valid_in;
         rd_last_ff     <= rd_last_in;
         pend_ff        <= pend_in;
         upd_emit_ff    <= upd_emit_in;
         first_ff       <= first_in;
         hit_ff         <= hit_in;
         rsp_valid_ff   <= rsp_valid_in;
         now_sec_ff     <= now_sec_in;
         now_nsec_ff    <= now_nsec_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_idx_ff    <= hit_idx_in;
      cmd_ff        <= cmd_in;
      min_sec_ff    <= min_sec_in;
      min_nsec_ff   <= min_nsec_in;
      pend_sec_ff   <= pend_sec_in;
      pend_nsec_ff  <= pend_nsec_in;
      pend_cause_ff <= pend_cause_in;
      upd_cause_ff  <= upd_cause_in;
      out_sec_ff    <= out_sec_in;
      out_nsec_ff   <= out_nsec_in;
      out_cause_ff  <= out_cause_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mtbs_pkg::RSP_DATA_W - SEC_W - NSEC_W){1'b0}}, out_nsec_ff, out_sec_ff};
   assign rsp_tuser  = out_cause_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CLIENTS))
      else $error("fill count beyond table depth");

   a_count_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff > FILL_W'(mtbs_pkg::CNT_MAX)) ? (count_ff == mtbs_pkg::CNT_MAX)
                                             : (FILL_W'(count_ff) == fill_ff))
      else $error("registration count out of step with table fill");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result beat overwritten while stalled");

   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == mtbs_pkg::ST_SEARCH || state_ff == mtbs_pkg::ST_MIN))
      else $error("table read data outside a scan");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      ((now_sec_in != now_sec_ff) || (now_nsec_in != now_nsec_ff)) |->
      (((now_sec_in == '0) && (now_nsec_in == '0)) ||
       !mtbs_pkg::time_less(now_sec_in, now_nsec_in, now_sec_ff, now_nsec_ff)))
      else $error("global time moved backward");

endmodule

>>> bench/tb_min_time_barrier_scheduler_unit.sv
// Self-checking testbench for min_time_barrier_scheduler_unit: drives command beats,
// predicts each published time beat and compares the result stream field by field.
// Depends on mtbs_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_min_time_barrier_scheduler_unit;

   localparam int ID_W         = mtbs_pkg::ID_W;
   localparam int SEC_W        = mtbs_pkg::SEC_W;
   localparam int NSEC_W       = mtbs_pkg::NSEC_W;
   localparam int OP_W         = mtbs_pkg::OP_W;
   localparam int CAUSE_W      = mtbs_pkg::CAUSE_W;
   localparam int CNT_W        = mtbs_pkg::CNT_W;
   localparam int REQ_DATA_W   = mtbs_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = mtbs_pkg::RSP_DATA_W;
   localparam int CSR_IDX_W    = mtbs_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W   = mtbs_pkg::CSR_DATA_W;
   localparam int TABLE_DEPTH  = mtbs_pkg::CLIENTS_DEFAULT;
   localparam int DRAIN_CYCLES = 120;
   localparam int LONG_STALL   = 400;
   localparam int ID_POOL      = 40;
   localparam int PAD_W        = REQ_DATA_W - ID_W - SEC_W - NSEC_W;
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   localparam logic [NSEC_W-1:0] NSEC_TOP = 30'd999999999;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      logic [SEC_W-1:0]  sec;
      logic [NSEC_W-1:0] nsec;
   } barrier_cmd_type;

   typedef struct packed {
      logic [SEC_W-1:0]   sec;
      logic [NSEC_W-1:0]  nsec;
      logic [CAUSE_W-1:0] cause;
      logic               last;
   } time_beat_type;

   // DUT ports, all inputs known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [CAUSE_W-1:0]    rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Stimulus and scoreboard
   barrier_cmd_type pending_cmds[$];
   barrier_cmd_type cur_cmd;
   time_beat_type   expected_times[$];
   time_beat_type   got_beat;
   time_beat_type   want_beat;
   bit              cmd_busy = 1'b0;
   int              cmds_offered = 0;
   int              cmds_taken = 0;
   int              error_count = 0;
   int              sender_idle_pct = 0;
   int              recv_idle_pct = 0;
   bit              long_stall_armed = 1'b0;
   int              stall_count = 0;
   logic [ID_W-1:0] id_pool [ID_POOL];
   int              limit_base = 20;

   // Predictor state: client table, global time, scheduler flags, registers
   logic                tbl_used [TABLE_DEPTH];
   logic [ID_W-1:0]     tbl_id   [TABLE_DEPTH];
   logic [SEC_W-1:0]    tbl_sec  [TABLE_DEPTH];
   logic [NSEC_W-1:0]   tbl_nsec [TABLE_DEPTH];
   logic [SEC_W-1:0]    now_sec = '0;
   logic [NSEC_W-1:0]   now_nsec = '0;
   logic                sched_running = 1'b0;
   logic                sched_paused = 1'b0;
   logic [CNT_W-1:0]    reg_count = '0;
   logic [CNT_W-1:0]    cfg_min_clients = '0;
   logic                cfg_autostart = 1'b0;
   time_beat_type       step_beats [0:1];
   int                  step_count;

   min_time_barrier_scheduler_unit #(.CLIENTS(TABLE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // a strictly before b: seconds first, raw nanoseconds second
   function automatic bit earlier(input logic [SEC_W-1:0] a_sec, input logic [NSEC_W-1:0] a_nsec,
                                  input logic [SEC_W-1:0] b_sec, input logic [NSEC_W-1:0] b_nsec);
      earlier = (a_sec < b_sec) || (a_sec == b_sec && a_nsec < b_nsec);
   endfunction

   task automatic add_beat(input logic [CAUSE_W-1:0] cause);
      step_beats[step_count] = '{sec: now_sec, nsec: now_nsec, cause: cause, last: 1'b0};
      step_count++;
   endtask

   // Move global time up to the lowest limit; an empty table zeroes it
   task automatic advance_time();
      bit                any_entry;
      logic [SEC_W-1:0]  low_sec;
      logic [NSEC_W-1:0] low_nsec;
      any_entry = 1'b0;
      low_sec = '0;
      low_nsec = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_used[i] && (!any_entry || earlier(tbl_sec[i], tbl_nsec[i], low_sec, low_nsec))) begin
            low_sec = tbl_sec[i];
            low_nsec = tbl_nsec[i];
            any_entry = 1'b1;
         end
      end
      if (any_entry) begin
         if (earlier(now_sec, now_nsec, low_sec, low_nsec)) begin
            now_sec = low_sec;
            now_nsec = low_nsec;
            add_beat(mtbs_pkg::CAUSE_ADVANCE);
         end
      end else begin
         now_sec = '0;
         now_nsec = '0;
         add_beat(mtbs_pkg::CAUSE_ZERO);
      end
   endtask

   // Known client: new limit. New client: store and echo, or drop when full.
   task automatic record_limit(input barrier_cmd_type c);
      int hit;
      int free_slot;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_used[i] && tbl_id[i] == c.id && hit < 0) hit = i;
         if (!tbl_used[i] && free_slot < 0) free_slot = i;
      end
      if (hit >= 0) begin
         tbl_sec[hit] = c.sec;
         tbl_nsec[hit] = c.nsec;
      end else if (free_slot >= 0) begin
         tbl_used[free_slot] = 1'b1;
         tbl_id[free_slot] = c.id;
         tbl_sec[free_slot] = c.sec;
         tbl_nsec[free_slot] = c.nsec;
         add_beat(mtbs_pkg::CAUSE_ECHO);
         if (reg_count < mtbs_pkg::CNT_MAX) reg_count++;
      end else begin
         add_beat(mtbs_pkg::CAUSE_DROPPED);
      end
   endtask

   task automatic predict_barrier(input barrier_cmd_type c);
      step_count = 0;
      case (c.op)
         mtbs_pkg::OP_NOTIFY: begin
            record_limit(c);
            if (!sched_paused && sched_running) begin
               advance_time();
            end else if (!sched_paused && cfg_autostart && reg_count >= cfg_min_clients) begin
               sched_running = 1'b1;
               advance_time();
            end
         end
         mtbs_pkg::OP_START: begin
            sched_running = 1'b1;
            advance_time();
         end
         mtbs_pkg::OP_PAUSE: begin
            sched_paused = !sched_paused;
            if (!sched_paused) advance_time();
         end
         default: ;
      endcase
      if (step_count > 0) step_beats[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++) expected_times.push_back(step_beats[i]);
   endtask

   // ---------------------------------------------------------------- command side

   // Driver: one beat held until taken, random gaps between beats
   always @(negedge clock) begin
      if (!reset) begin
         if (cmd_busy && cmds_taken == cmds_offered) cmd_busy = 1'b0;
         if (!cmd_busy && pending_cmds.size() > 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            cur_cmd = pending_cmds.pop_front();
            cmd_busy = 1'b1;
            cmds_offered++;
            req_tdata <= {{PAD_W{1'b0}}, cur_cmd.nsec, cur_cmd.sec, cur_cmd.id};
            req_tuser <= cur_cmd.op;
         end
         req_tvalid <= cmd_busy;
      end
   end

   // Accepted command beats feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_barrier(cur_cmd);
         cmds_taken++;
      end
   end

   // ---------------------------------------------------------------- result side

   // Receiver: one long hold-off when armed, otherwise random stalls
   always @(negedge clock) begin
      if (long_stall_armed && stall_count < LONG_STALL) begin
         stall_count++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat = '{sec: rsp_tdata[30:0], nsec: rsp_tdata[60:31], cause: rsp_tuser,
                      last: rsp_tlast};
         if (expected_times.size() == 0) begin
            $error("result beat with nothing pending: sec %0d nsec %0d cause %0d",
                   got_beat.sec, got_beat.nsec, got_beat.cause);
            error_count++;
         end else begin
            want_beat = expected_times.pop_front();
            check_field("time_sec", want_beat.sec, got_beat.sec);
            check_field("time_nanosec", want_beat.nsec, got_beat.nsec);
            check_field("cause", want_beat.cause, got_beat.cause);
            check_field("last", want_beat.last, got_beat.last);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [SEC_W-1:0] sec, input logic [NSEC_W-1:0] nsec);
      barrier_cmd_type c;
      c = '{op: op, id: id, sec: sec, nsec: nsec};
      pending_cmds.push_back(c);
   endtask

   // Mostly notifies from a fixed id pool with slowly rising limits, some noise
   task automatic queue_random_cmds(input int count);
      barrier_cmd_type c;
      int              pick;
      int              n;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         c.id = ID_W'($urandom());
         c.sec = SEC_W'($urandom());
         c.nsec = NSEC_W'($urandom());
         if (pick < 78) begin
            c.op = mtbs_pkg::OP_NOTIFY;
            if ($urandom_range(0, 99) < 85) c.id = id_pool[$urandom_range(0, ID_POOL-1)];
            if ($urandom_range(0, 99) >= 5) begin
               c.sec = SEC_W'(limit_base + $urandom_range(0, 3));
               limit_base += $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) c.nsec = '0;
            else if (pick < 10) c.nsec = NSEC_TOP;
            else if (pick >= 20) c.nsec = NSEC_W'($urandom_range(0, 999999999));
         end else if (pick < 85) begin
            c.op = mtbs_pkg::OP_START;
         end else if (pick < 94) begin
            c.op = mtbs_pkg::OP_PAUSE;
         end else begin
            c.op = OP_IGNORED;
         end
         pending_cmds.push_back(c);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == mtbs_pkg::CSR_MIN_CLIENTS) cfg_min_clients = value;
      else cfg_autostart = value[0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Block until every command is taken and answered, then let the unit settle
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || cmds_taken != cmds_offered ||
             expected_times.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      id_pool[2] = 16'h1234;
      id_pool[3] = 16'h00AA;
      id_pool[4] = 16'h5555;
      for (int i = 5; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom());

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: autostart after three registrations, pause and start corners
      write_csr(mtbs_pkg::CSR_MIN_CLIENTS, 6'd3);
      write_csr(mtbs_pkg::CSR_AUTOSTART, 6'd1);
      queue_cmd(OP_IGNORED, 16'h0000, '0, '0);
      queue_cmd(mtbs_pkg::OP_PAUSE, 16'hFFFF, '1, '1);
      queue_cmd(mtbs_pkg::OP_PAUSE, 16'h0000, '0, '0);            // unpause, empty table
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h0000, 31'd5, 30'd100);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'hFFFF, '1, '1);           // raw nanoseconds
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h0000, 31'd6, 30'd0);     // known, not yet running
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h1234, 31'd5, NSEC_TOP);  // autostart
      queue_cmd(mtbs_pkg::OP_PAUSE, 16'h0000, '0, '0);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h0000, 31'd8, 30'd0);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h1234, 31'd9, 30'd0);
      queue_cmd(mtbs_pkg::OP_PAUSE, 16'h0000, '0, '0);            // unpause advances
      queue_cmd(mtbs_pkg::OP_PAUSE, 16'h0000, '0, '0);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h0000, 31'd8, 30'd1);
      queue_cmd(mtbs_pkg::OP_START, 16'h0000, '0, '0);            // start while paused
      queue_cmd(mtbs_pkg::OP_PAUSE, 16'h0000, '0, '0);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h0000, 31'd0, 30'd0);     // limit below now
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h00AA, 31'd8, 30'd1);     // equal to now
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h5555, 31'd1, '1);
      queue_cmd(OP_IGNORED, 16'hFFFF, '1, '1);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h0000, 31'd9, '1);
      queue_cmd(mtbs_pkg::OP_NOTIFY, 16'h5555, 31'd12, NSEC_TOP);
      queue_cmd(mtbs_pkg::OP_START, 16'h0000, '0, '0);
      wait_drained();

      // Random, slow receiver, with one long hold-off
      write_csr(mtbs_pkg::CSR_MIN_CLIENTS, 6'd0);
      write_csr(mtbs_pkg::CSR_AUTOSTART, 6'd0);
      sender_idle_pct = 6;
      recv_idle_pct = 81;
      queue_random_cmds(200);
      long_stall_armed = 1'b1;
      wait_drained();

      // Random, slow sender
      write_csr(mtbs_pkg::CSR_MIN_CLIENTS, 6'd17);
      write_csr(mtbs_pkg::CSR_AUTOSTART, 6'd1);
      sender_idle_pct = 81;
      recv_idle_pct = 6;
      queue_random_cmds(200);
      wait_drained();

      // Random, full rate both sides
      write_csr(mtbs_pkg::CSR_MIN_CLIENTS, 6'd32);
      sender_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_cmds(200);
      wait_drained();

      if (error_count == 0 && expected_times.size() == 0)
         $display("min_time_barrier_scheduler_unit verification clean");
      else
         $display("min_time_barrier_scheduler_unit verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("min_time_barrier_scheduler_unit verification failed");
      $finish;
   end

endmodule
